// ----- design/lisl_pkg.sv -----
// ----------------------------------------------------------------------------
// lisl_pkg: shared types for the longest increasing subsequence length block
// controller states, command and status bundles, sign flip constant
// ----------------------------------------------------------------------------
package lisl_pkg;

  // flipping the sign bit makes an unsigned compare follow the signed order
  localparam logic [31:0] KEY_FLIP = 32'h8000_0000;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_CMP   = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture a new request and start the search
    logic read;    // read the tail at the midpoint
    logic cmp;     // narrow the search window
    logic write;   // update the tails store, emit the result on last
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic search_done;   // window is empty, lo marks the slot
    logic last;          // request carries the last mark
    logic out_blocked;   // previous result still held by a stalled receiver
  } status_t;

endpackage

// ----- design/lisl_ctrl.sv -----
// ----------------------------------------------------------------------------
// lisl_ctrl: sequencer for the tails search
// steps load, midpoint read, compare and store update for each request
// ----------------------------------------------------------------------------
module lisl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  lisl_pkg::status_t status,
  output lisl_pkg::cmd_t    cmd
);
  import lisl_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (status.search_done) begin
          state_next = S_WRITE;
        end else begin
          cmd.read   = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_READ;
      end
      S_WRITE: begin
        // hold a last request while the result slot is occupied and stalled
        if (!(status.last && status.out_blocked)) begin
          cmd.write  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.read, cmd.cmp, cmd.write}))
    else $error("more than one datapath command at once");

  a_cmp_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.read |=> cmd.cmp)
    else $error("compare did not follow a tail read");

endmodule

// ----- design/lisl_dp.sv -----
// ----------------------------------------------------------------------------
// lisl_dp: datapath for the tails search
// tails memory, binary search window, count, overflow and result register
// ----------------------------------------------------------------------------
module lisl_dp #(
  parameter int MAX_LEN = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] value,
  input  logic               last,
  input  lisl_pkg::cmd_t     cmd,
  output lisl_pkg::status_t  status,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [10:0]        lis_length,
  output logic               overflow
);
  import lisl_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

  logic [31:0]   tails [MAX_LEN];
  logic [31:0]   rd_data;
  logic [31:0]   key;
  logic          last_r;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW-1:0] mid;
  logic [CW-1:0] mid_r;
  logic [CW-1:0] count;
  logic          ovf_seen;

  logic          at_end;
  logic          do_store;
  logic          do_append;
  logic          do_drop;
  logic [CW-1:0] count_next;

  assign mid = lo + ((hi - lo) >> 1);

  // slot is past the last tail: append, or drop when full
  assign at_end     = (lo == count);
  assign do_append  = at_end && (count != FULL);
  assign do_drop    = at_end && (count == FULL);
  assign do_store   = !do_drop;
  assign count_next = do_append ? count + CW'(1) : count;

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data <= tails[mid[AW-1:0]];
    end
    if (cmd.write && do_store) begin
      tails[lo[AW-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key    <= $unsigned(value) ^ KEY_FLIP;
      last_r <= last;
    end
    if (cmd.read) begin
      mid_r <= mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo        <= '0;
      hi        <= '0;
      count     <= '0;
      ovf_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a new result may replace one that leaves at the same edge
      if (cmd.write && last_r) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        lo <= '0;
        hi <= count;
      end
      if (cmd.cmp) begin
        if (rd_data < key) begin
          lo <= mid_r + CW'(1);
        end else begin
          hi <= mid_r;
        end
      end
      if (cmd.write) begin
        if (last_r) begin
          lis_length <= 11'(count_next);
          overflow   <= ovf_seen | do_drop;
          count      <= '0;
          ovf_seen   <= 1'b0;
        end else begin
          count    <= count_next;
          ovf_seen <= ovf_seen | do_drop;
        end
      end
    end
  end

  assign status.search_done = (lo == hi);
  assign status.last        = last_r;
  assign status.out_blocked = out_valid && out_stall;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("tail count above store depth");

  a_window_order: assert property (@(posedge clk) disable iff (rst)
    lo <= hi)
    else $error("search window inverted");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.write && last_r) |=> (out_valid && count == '0 && !ovf_seen))
    else $error("last request did not emit a result and clear state");

endmodule

// ----- design/longest_increasing_subsequence_length.sv -----
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_length: streaming lis length
// tails-method binary search over an on-chip store, one result per sequence
// ----------------------------------------------------------------------------
// input: in_valid / in_stall with value (signed 32-bit) and last; a request
//   is taken on a rising edge with in_valid high and in_stall low
// output: out_valid / out_stall with lis_length and overflow; one result per
//   sequence, on the request that carries last
// per request: an accept state, then a tail read and a compare per search
//   step on the single memory read port, a state to close the search and the
//   store update; the next request is taken only once the update is done
// result: the result shows on the output the cycle after the update of the
//   last request
// stall: a result waits in the output register; the next sequence keeps being
//   taken, and only its own last request holds in the update step until the
//   waiting result has left
// reset: clears the count, the overflow mark and the output valid; the tails
//   memory is not cleared since only entries below the count are ever read
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_length #(
  parameter int MAX_LEN = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] value,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [10:0]        lis_length,
  output logic               overflow
);
  import lisl_pkg::*;

  // command and status bundles between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: accept, search steps, store update
  lisl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: tails memory, search window, count and result register
  lisl_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .last       (last),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .lis_length (lis_length),
    .overflow   (overflow)
  );

endmodule

// ----- dv/tb_longest_increasing_subsequence_length.sv -----
// ----------------------------------------------------------------------------
// tb_longest_increasing_subsequence_length: self-checking bench for the block
// feeds sequences of signed values through the valid/stall request channel,
// keeps its own tails store to work out each sequence's length and overflow
// mark, and checks every result on the output channel in order
// ----------------------------------------------------------------------------
module tb_longest_increasing_subsequence_length;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 1024;
  localparam int HOLD_CYCLES = 600;    // long receiver hold-off, fills the block
  localparam int WATCHDOG    = 5000;   // cycles without any handshake
  localparam int DRAIN       = 60;     // settle time after the last result
  localparam int RANDOM_REQS = 300;
  localparam int LONG_RUN    = 160;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic signed [31:0] v;
    logic               fin;
  } request_t;

  typedef struct {
    logic [10:0] len;
    logic        ovf;
  } lis_result_t;

  // flavors of random sequence content
  typedef enum {MIX_ANY, MIX_NARROW, MIX_WALK, MIX_EDGES} mix_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] value = '0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [10:0]        lis_length;
  logic               overflow;

  // requests waiting to be driven, results waiting to come out
  request_t    seq_items[$];
  lis_result_t length_due[$];

  // local tails store mirroring the block's state
  logic signed [31:0] tails_m [DEPTH];
  int                 tail_cnt = 0;
  bit                 store_full = 1'b0;

  int errors = 0;
  int total_items = 0;
  int items_taken = 0;
  int quiet_cycles = 0;
  bit stuck = 1'b0;
  bit busy;

  longest_increasing_subsequence_length #(
    .MAX_LEN(DEPTH)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .lis_length (lis_length),
    .overflow   (overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // idle length: mostly none, some short, a few long; none in a calm stretch
  function automatic int idle_span(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one value into the tails store: replace the first tail >= v or append;
  // on the last mark the length and overflow are due and the store clears
  function automatic void lis_absorb(input logic signed [31:0] v, input logic fin);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = tail_cnt;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (tails_m[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    if (lo < tail_cnt) tails_m[lo] = v;
    else if (tail_cnt < DEPTH) begin
      tails_m[tail_cnt] = v;
      tail_cnt++;
    end else begin
      // store full, value dropped
      store_full = 1'b1;
    end
    if (fin) begin
      length_due.push_back('{len: tail_cnt[10:0], ovf: store_full});
      tail_cnt = 0;
      store_full = 1'b0;
    end
  endfunction

  task automatic push_item(input logic signed [31:0] v, input logic fin);
    seq_items.push_back('{v: v, fin: fin});
    total_items++;
  endtask

  // strictly rising run of n values, last mark on the final one
  task automatic add_rising_run(input int n);
    longint acc;
    acc = -64'sd2147483648 + longint'($urandom_range(0, 1 << 30));
    for (int i = 0; i < n; i++) begin
      push_item(acc[31:0], i == n - 1);
      acc += longint'($urandom_range(1, 1 << 21));
    end
  endtask

  // driver: holds a request while stalled, otherwise idles or loads the next
  int  tx_idle = 0;
  bit  tx_calm = 1'b0;
  always @(posedge clk) begin : driver
    request_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
      if (!in_valid || !in_stall) begin
        if (tx_idle > 0) begin
          tx_idle--;
          in_valid <= 1'b0;
        end else if (seq_items.size() > 0) begin
          req = seq_items.pop_front();
          in_valid <= 1'b1;
          value    <= req.v;
          last     <= req.fin;
          tx_idle  = idle_span(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off after the third result
  int rx_stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit rx_calm = 1'b0;
  int results_taken = 0;
  always @(posedge clk) begin : receiver
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) results_taken++;
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_taken == 3) begin
        // sender keeps offering during this, so the block backs up
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        rx_stall_left = idle_span(rx_calm);
      end
    end
  end

  // monitor: predicts on each accepted request, checks each accepted result
  always @(posedge clk) begin : monitor
    lis_result_t due;
    if (!rst) begin
      busy = 1'b0;
      if (in_valid && !in_stall) begin
        lis_absorb(value, last);
        items_taken++;
        busy = 1'b1;
      end
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (length_due.size() == 0) begin
          $error("result with no sequence pending: lis_length %0d overflow %0b",
                 lis_length, overflow);
          errors++;
        end else begin
          due = length_due.pop_front();
          if (lis_length !== due.len) begin
            $error("lis_length: expected %0d, got %0d", due.len, lis_length);
            errors++;
          end
          if (overflow !== due.ovf) begin
            $error("overflow: expected %0b, got %0b", due.ovf, overflow);
            errors++;
          end
        end
      end
      if (busy) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) stuck = 1'b1;
    end
  end

  initial begin : stimulus
    int   n;
    int   rand_items;
    int   walk;
    logic signed [31:0] v;
    mix_t mix;

    // single elements at both extremes
    push_item(VAL_MIN, 1'b1);
    push_item(VAL_MAX, 1'b1);
    // rising across the sign boundary, full range
    push_item(VAL_MIN, 1'b0);
    push_item(-32'sd1, 1'b0);
    push_item(32'sd0, 1'b0);
    push_item(32'sd1, 1'b0);
    push_item(VAL_MAX, 1'b1);
    // equal values never extend
    repeat (3) push_item(32'sd5, 1'b0);
    push_item(32'sd5, 1'b1);
    // falling
    push_item(VAL_MAX, 1'b0);
    push_item(32'sd0, 1'b0);
    push_item(VAL_MIN, 1'b1);
    // mixed, with a repeat and replacements
    push_item(32'sd3, 1'b0);
    push_item(32'sd1, 1'b0);
    push_item(32'sd4, 1'b0);
    push_item(32'sd1, 1'b0);
    push_item(32'sd5, 1'b0);
    push_item(32'sd9, 1'b0);
    push_item(32'sd2, 1'b0);
    push_item(32'sd6, 1'b1);

    // one long rising run for deep searches
    add_rising_run(LONG_RUN);

    rand_items = 0;
    while (rand_items < RANDOM_REQS) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
      mix = mix_t'($urandom_range(0, 3));
      walk = $urandom;
      for (int k = 0; k < n; k++) begin
        case (mix)
          MIX_ANY:    v = $urandom;
          MIX_NARROW: v = $urandom_range(0, 7) - 4;   // lots of equal values
          MIX_WALK: begin
            walk = walk + $urandom_range(0, 2000) - 500;
            v = walk;
          end
          default: begin
            case ($urandom_range(0, 4))
              0:       v = VAL_MIN;
              1:       v = VAL_MAX;
              2:       v = -32'sd1;
              3:       v = 32'sd0;
              default: v = $urandom;
            endcase
          end
        endcase
        push_item(v, k == n - 1);
      end
      rand_items += n;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (!stuck && (items_taken < total_items || length_due.size() > 0))
      @(posedge clk);

    if (stuck) begin
      $display("TEST FAILED");
    end else begin
      repeat (DRAIN) @(posedge clk);
      if (length_due.size() != 0) begin
        $error("%0d results never arrived", length_due.size());
        errors++;
      end
      if (errors == 0) begin
        $display("TEST PASSED");
      end else begin
        $display("TEST FAILED");
      end
    end
    $finish;
  end

endmodule
